FILE: design/z85_pkg.sv
// ----------------------------------------------------------------------------
// z85_pkg: shared types, codes and alphabet functions for the Z85 block codec
// Digit/character mapping for the 85-symbol alphabet and the lane record
// that moves down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package z85_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int WORD_W     = 32;
  localparam int TEXT_W     = 8 * NUM_DIGITS;
  localparam int ACC_W      = 33;  // 85^5 - 1 needs 33 bits

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // floor(2^38 / 85); quotient estimate is exact or one low for 32-bit x
  localparam logic [31:0] RECIP_85 = 32'd3233857728;
  localparam int          RECIP_SH = 38;

  typedef struct packed {
    logic              kind;
    logic              bad;
    logic [ACC_W-1:0]  acc;
    logic [TEXT_W-1:0] text;
  } z85_lane_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] val;
  } z85_digit_t;

  function automatic logic [7:0] z85_char(input logic [6:0] d);
    logic [7:0] c;
    c = 8'h00;
    if (d < 7'd10) begin
      c = 8'h30 + {1'b0, d};
    end else if (d < 7'd36) begin
      c = 8'h61 + {1'b0, d} - 8'd10;
    end else if (d < 7'd62) begin
      c = 8'h41 + {1'b0, d} - 8'd36;
    end else begin
      case (d)
        7'd62: c = 8'h2E;
        7'd63: c = 8'h2D;
        7'd64: c = 8'h3A;
        7'd65: c = 8'h2B;
        7'd66: c = 8'h3D;
        7'd67: c = 8'h5E;
        7'd68: c = 8'h21;
        7'd69: c = 8'h2F;
        7'd70: c = 8'h2A;
        7'd71: c = 8'h3F;
        7'd72: c = 8'h26;
        7'd73: c = 8'h3C;
        7'd74: c = 8'h3E;
        7'd75: c = 8'h28;
        7'd76: c = 8'h29;
        7'd77: c = 8'h5B;
        7'd78: c = 8'h5D;
        7'd79: c = 8'h7B;
        7'd80: c = 8'h7D;
        7'd81: c = 8'h40;
        7'd82: c = 8'h25;
        7'd83: c = 8'h24;
        7'd84: c = 8'h23;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic z85_digit_t z85_digit(input logic [7:0] c);
    z85_digit_t r;
    r.ok  = 1'b1;
    r.val = 7'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 7'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 7'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 7'(c - 8'h41 + 8'd36);
    end else begin
      case (c)
        8'h2E: r.val = 7'd62;
        8'h2D: r.val = 7'd63;
        8'h3A: r.val = 7'd64;
        8'h2B: r.val = 7'd65;
        8'h3D: r.val = 7'd66;
        8'h5E: r.val = 7'd67;
        8'h21: r.val = 7'd68;
        8'h2F: r.val = 7'd69;
        8'h2A: r.val = 7'd70;
        8'h3F: r.val = 7'd71;
        8'h26: r.val = 7'd72;
        8'h3C: r.val = 7'd73;
        8'h3E: r.val = 7'd74;
        8'h28: r.val = 7'd75;
        8'h29: r.val = 7'd76;
        8'h5B: r.val = 7'd77;
        8'h5D: r.val = 7'd78;
        8'h7B: r.val = 7'd79;
        8'h7D: r.val = 7'd80;
        8'h40: r.val = 7'd81;
        8'h25: r.val = 7'd82;
        8'h24: r.val = 7'd83;
        8'h23: r.val = 7'd84;
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/z85_block_codec.sv
// ----------------------------------------------------------------------------
// z85_block_codec: Z85 encode/decode of one 32-bit block per item
// Five identical digit cells in a chain; each item walks through all five,
// one digit per cell, and the last cell's register drives the result.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | in_kind, in_data
//   out     | source    | out_valid/out_stall| out_data, out_status
//
// Each digit cell registers its item; one item per cycle is sustained while out_stall is low.
// in_stall rises only when every cell holds an item and out_stall is high:
// the stall ripples back through the chain in the same cycle, so bubbles
// are squeezed out. Reset clears all cell valid bits; no clearing time.
// ----------------------------------------------------------------------------
`default_nettype none

module z85_block_codec (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [39:0] in_data,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [39:0] out_data,
  output logic [1:0]  out_status
);
  import z85_pkg::*;

  z85_lane_t            lane  [NUM_DIGITS+1];
  logic [NUM_DIGITS:0]  vld;
  logic [NUM_DIGITS-1:0] adv;
  z85_lane_t            last;

  assign vld[0]       = in_valid;
  assign lane[0].kind = in_kind;
  assign lane[0].bad  = 1'b0;
  assign lane[0].acc  = (in_kind == KIND_ENCODE) ?
                        {{(ACC_W-WORD_W){1'b0}}, in_data[WORD_W-1:0]} : '0;
  assign lane[0].text = (in_kind == KIND_ENCODE) ? '0 : in_data;

  // a cell takes new data when empty or when its item moves on
  assign adv[NUM_DIGITS-1] = ~vld[NUM_DIGITS] | ~out_stall;

  genvar g;
  generate
    for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
      if (g < NUM_DIGITS-1) begin : g_adv
        assign adv[g] = ~vld[g+1] | adv[g+1];
      end
      z85_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (adv[g]),
        .in_valid    (vld[g]),
        .in_lane     (lane[g]),
        .out_valid_r (vld[g+1]),
        .out_lane_r  (lane[g+1])
      );
    end
  endgenerate

  assign in_stall = ~adv[0];
  assign last     = lane[NUM_DIGITS];
  assign out_valid = vld[NUM_DIGITS];

  always_comb begin
    out_data   = last.text;
    out_status = ST_OK;
    if (last.kind == KIND_DECODE) begin
      if (last.bad) begin
        out_data   = '0;
        out_status = ST_BAD_CHAR;
      end else begin
        out_data   = {{(TEXT_W-WORD_W){1'b0}}, last.acc[WORD_W-1:0]};
        out_status = last.acc[ACC_W-1] ? ST_OVERFLOW : ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/z85_cell.sv
// ----------------------------------------------------------------------------
// z85_cell: one digit step of the Z85 chain
// Encode: peels the low base-85 digit off the word and pushes its character
// in at the top of the text. Decode: pops the top character and folds its
// digit into the accumulator (acc * 85 + d).
// ----------------------------------------------------------------------------
`default_nettype none

module z85_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  wire                 in_valid,
  input  z85_pkg::z85_lane_t  in_lane,
  output logic                out_valid_r,
  output z85_pkg::z85_lane_t  out_lane_r
);
  import z85_pkg::*;

  z85_lane_t            lane_nxt;
  logic [WORD_W-1:0]    x;
  logic [63:0]          prod;
  logic [25:0]          q_est;
  logic [7:0]           q_lo85;
  logic [7:0]           r_est;
  logic                 fix;
  logic [6:0]           rem;
  logic [25:0]          quo;
  z85_digit_t           dig;
  logic [ACC_W-1:0]     acc_x85;

  // encode: reciprocal multiply, remainder only needs the low byte
  assign x      = in_lane.acc[WORD_W-1:0];
  assign prod   = x * RECIP_85;
  assign q_est  = prod[63:RECIP_SH];
  assign q_lo85 = 8'(q_est[7:0] * 8'd85);
  assign r_est  = x[7:0] - q_lo85;
  assign fix    = (r_est >= 8'd85);
  assign rem    = fix ? 7'(r_est - 8'd85) : r_est[6:0];
  assign quo    = q_est + 26'(fix);

  // decode: x85 as shift-add
  assign dig     = z85_digit(in_lane.text[TEXT_W-1 -: 8]);
  assign acc_x85 = (in_lane.acc << 6) + (in_lane.acc << 4) + (in_lane.acc << 2)
                   + in_lane.acc;

  always_comb begin
    lane_nxt      = in_lane;
    if (in_lane.kind == KIND_ENCODE) begin
      lane_nxt.acc  = {{(ACC_W-26){1'b0}}, quo};
      lane_nxt.text = {z85_char(rem), in_lane.text[TEXT_W-1:8]};
    end else begin
      lane_nxt.acc  = acc_x85 + {{(ACC_W-7){1'b0}}, (dig.ok ? dig.val : 7'd0)};
      lane_nxt.bad  = in_lane.bad | ~dig.ok;
      lane_nxt.text = {in_lane.text[TEXT_W-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_lane_r <= lane_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/z85_checker.sv
// ----------------------------------------------------------------------------
// z85_checker: port-level checks for the Z85 block codec
// Watches the handshakes and the result codes on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module z85_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        in_kind,
  input wire [39:0] in_data,
  input wire        out_valid,
  input wire        out_stall,
  input wire [39:0] out_data,
  input wire [1:0]  out_status
);
  import z85_pkg::*;

  // a stalled input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_data))
    else $error("stalled input item changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("stalled result changed");

  // with the output empty the chain can always take an item
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_CHAR ||
                   out_status == ST_OVERFLOW))
    else $error("undefined status code");

  // a rejected decode gives a zero word
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_CHAR |-> out_data == '0)
    else $error("bad-character result not zero");

endmodule

bind z85_block_codec z85_checker u_z85_checker (.*);

`default_nettype wire

FILE: tb/z85_block_codec_tb.sv
// ----------------------------------------------------------------------------
// z85_block_codec_tb: self-checking testbench for the Z85 block codec
// Drives directed encode and decode items, then random bursts, against a stalling
// receiver. Each accepted item is converted by a behavioral Z85 converter
// and the result is compared in order against what the block produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module z85_block_codec_tb;
  import z85_pkg::*;

  localparam int RANDOM_BLOCKS = 1900;

  typedef struct {
    logic [39:0] text;
    logic [1:0]  status;
  } z85_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class z85_scoreboard;
    byte unsigned glyph[85];
    int           digit_of[256];
    z85_result_t  want_q[$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      string s;
      s = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
      mismatches = 0;
      checked    = 0;
      foreach (digit_of[i]) digit_of[i] = -1;
      for (int i = 0; i < 85; i++) begin
        glyph[i]       = s[i];
        digit_of[s[i]] = i;
      end
    endfunction

    function bit is_glyph(input logic [7:0] c);
      return digit_of[c] >= 0;
    endfunction

    function z85_result_t convert(input logic kind, input logic [39:0] data);
      z85_result_t     r;
      logic [31:0]     w;
      longint unsigned value;
      bit              bad;
      int              d;
      r.text   = '0;
      r.status = ST_OK;
      if (kind == KIND_ENCODE) begin
        w = data[31:0];
        for (int i = 4; i >= 0; i--) begin
          r.text[8*(4-i) +: 8] = glyph[w % 85];
          w = w / 85;
        end
      end else begin
        value = 0;
        bad   = 1'b0;
        for (int i = 0; i < 5; i++) begin
          d = digit_of[data[8*(4-i) +: 8]];
          if (d < 0) begin
            bad = 1'b1;
            d   = 0;
          end
          value = value * 85 + longint'(d);
        end
        if (bad) begin
          r.status = ST_BAD_CHAR;
        end else begin
          // values past 2^32-1 are flagged but still return the low word
          if (value > 64'hFFFF_FFFF) r.status = ST_OVERFLOW;
          r.text = 40'(value & 64'hFFFF_FFFF);
        end
      end
      return r;
    endfunction

    function void note_block(input logic kind, input logic [39:0] data);
      want_q.push_back(convert(kind, data));
    endfunction

    function void check_result(input logic [39:0] text, input logic [1:0] status);
      z85_result_t want;
      checked++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with no item pending: data %h status %0d",
                   checked, text, status);
        return;
      end
      want = want_q.pop_front();
      if (text !== want.text || status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: data exp %h got %h, status exp %0d got %0d",
                   checked, want.text, text, want.status, status);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_kind    = KIND_ENCODE;
  logic [39:0] in_data    = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [39:0] out_data;
  logic [1:0]  out_status;

  z85_scoreboard sb = new();

  stall_mode_t stall_mode  = STALL_NONE;
  int unsigned stall_cycle = 0;

  z85_block_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_status (out_status)
  );

  always #1 clk = ~clk;

  // receiver back-pressure in one of four randomly picked modes
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 97 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
      default:     out_stall <= (stall_cycle % 8) >= 5;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_block(in_kind, in_data);
      if (out_valid && !out_stall) sb.check_result(out_data, out_status);
    end
  end

  task automatic send_block(input logic kind, input logic [39:0] data);
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [39:0] text_of(input string s);
    logic [39:0] r;
    for (int i = 0; i < 5; i++) r[8*(4-i) +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (sb.is_glyph(b));
    return b;
  endfunction

  task automatic pick_block(output logic kind, output logic [39:0] data);
    int sel;
    int pos;
    sel  = $urandom_range(0, 99);
    kind = KIND_DECODE;
    data = '0;
    if (sel < 30) begin
      kind = KIND_ENCODE;
      data = {8'($urandom), 32'($urandom)};
    end else if (sel < 90) begin
      for (int i = 0; i < 5; i++) data[8*(4-i) +: 8] = sb.glyph[$urandom_range(0, 84)];
      // push the leading digit toward the 32-bit boundary (82 vs 83)
      if (sel >= 70 && sel < 80) data[39:32] = sb.glyph[$urandom_range(80, 84)];
      if (sel >= 80) begin
        pos = $urandom_range(0, 4);
        data[8*pos +: 8] = stray_byte();
      end
    end else begin
      data = {8'($urandom), 32'($urandom)};
    end
  endtask

  initial begin
    int          sent;
    int          burst;
    logic        kind;
    logic [39:0] data;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_block(KIND_ENCODE, 40'h00_0000_0000);
    send_block(KIND_ENCODE, 40'h00_FFFF_FFFF);
    send_block(KIND_ENCODE, 40'hFF_FFFF_FFFF);      // upper byte ignored
    send_block(KIND_ENCODE, 40'hAA_864F_D26F);
    send_block(KIND_ENCODE, 40'h00_0000_0055);
    send_block(KIND_ENCODE, 40'h80_8000_0000);
    send_block(KIND_DECODE, text_of("00000"));
    send_block(KIND_DECODE, text_of("%nSc0"));
    send_block(KIND_DECODE, text_of("%nSc1"));      // just past 2^32-1
    send_block(KIND_DECODE, text_of("#####"));      // 85^5-1
    send_block(KIND_DECODE, text_of("Hello"));
    send_block(KIND_DECODE, text_of(" ello"));
    send_block(KIND_DECODE, text_of("H\"llo"));
    send_block(KIND_DECODE, {text_of("He0lo") & 40'hFF_FF00_FFFF} | 40'h00_007F_0000);
    send_block(KIND_DECODE, text_of("Hel0o") & 40'hFF_FFFF_00FF);
    send_block(KIND_DECODE, text_of("Hell0") | 40'h00_0000_00FF);
    send_block(KIND_DECODE, 40'h00_0000_0000);
    send_block(KIND_DECODE, 40'hFF_FFFF_FFFF);
    send_block(KIND_DECODE, text_of("##~##"));      // bad char wins over overflow
    pause(3);

    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst; j++) begin
        pick_block(kind, data);
        send_block(kind, data);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
